FILE: sv/btn_pkg.sv
package btn_pkg;

  // Fixed field widths of the transaction ports
  localparam int ACT_W         = 4;
  localparam int KEY_FIELD_W   = 32;
  localparam int CHILD_FIELD_W = 16;
  localparam int POS_W         = 5;
  localparam int IDX_FIELD_W   = 5;
  localparam int CNT_FIELD_W   = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT     = 4'd0,
    ACT_ROUTE      = 4'd1,
    ACT_FIND_KEY   = 4'd2,
    ACT_FIND_CHILD = 4'd3,
    ACT_READ       = 4'd4,
    ACT_UPDATE     = 4'd5,
    ACT_DEL_KEY    = 4'd6,
    ACT_DEL_CHILD  = 4'd7,
    ACT_START      = 4'd8
  } act_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_CREAD,
    S_CGET,
    S_BS_RD,
    S_BS_CMP,
    S_PREAD,
    S_PGET,
    S_START2,
    S_FIN
  } seq_state_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic key_lt;    // key_a < key_b, unsigned
    logic key_eq;
    logic child_eq;
  } cmp_res_t;

endpackage

FILE: sv/btn_ram.sv
module btn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/btn_cmp.sv
module btn_cmp import btn_pkg::*; #(
  parameter int KEY_W   = 32,
  parameter int CHILD_W = 16
) (
  input  logic [KEY_W-1:0]   key_a,
  input  logic [KEY_W-1:0]   key_b,
  input  logic [CHILD_W-1:0] child_a,
  input  logic [CHILD_W-1:0] child_b,
  output cmp_res_t           res
);

  always_comb begin
    res.key_lt   = (key_a < key_b);
    res.key_eq   = (key_a == key_b);
    res.child_eq = (child_a == child_b);
  end

endmodule

FILE: sv/btree_inner_node_key_store.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------------
// in_      | input     | in_valid/in_stall  | action, search_key, child_id, left_child_id,
//          |           |                    | position
// out_     | output    | out_valid/out_stall| status, found_index, key_out, child_out,
//          |           |                    | key_count, child_count
//
// One transaction at a time; in_stall is high from acceptance until the result has been
// loaded into the output register. Transaction time grows with the keys held (key scans and
// binary search probes), with the children held (child scan) and with the entries that an
// insert or a delete moves. It is set by the single read port of each slot RAM and the one
// comparator that every scan and probe goes through.
// Reset (rst_n low, synchronous) empties the node: both counts go to zero, the sequencer
// returns to idle and out_valid drops. Slot contents are not cleared.
// A held result waits in the output register under out_stall while the next transaction
// is accepted and worked on; it is replaced only once taken.
module btree_inner_node_key_store import btn_pkg::*; #(
  parameter int MAX_KEYS   = 16,
  parameter int KEY_BITS   = 32,
  parameter int CHILD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [KEY_FIELD_W-1:0]   in_search_key,
  input  logic [CHILD_FIELD_W-1:0] in_child_id,
  input  logic [CHILD_FIELD_W-1:0] in_left_child_id,
  input  logic [POS_W-1:0]         in_position,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [IDX_FIELD_W-1:0]   out_found_index,
  output logic [KEY_FIELD_W-1:0]   out_key_out,
  output logic [CHILD_FIELD_W-1:0] out_child_out,
  output logic [CNT_FIELD_W-1:0]   out_key_count,
  output logic [CNT_FIELD_W-1:0]   out_child_count
);

  // Count width holds MAX_KEYS + 1 (children)
  localparam int CNT_W = $clog2(MAX_KEYS + 2);
  localparam int KAW   = $clog2(MAX_KEYS);
  localparam int CAW   = $clog2(MAX_KEYS + 1);
  // Index results also carry the raw position field
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] KEY_CAP   = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] CHILD_CAP = CNT_W'(MAX_KEYS + 1);

  seq_state_t state_r, state_nxt;

  // Captured transaction
  act_t                  act_r,   act_nxt;
  logic [KEY_BITS-1:0]   key_r,   key_nxt;
  logic [CHILD_BITS-1:0] child_r, child_nxt;
  logic [CHILD_BITS-1:0] left_r,  left_nxt;
  logic [POS_W-1:0]      pos_r,   pos_nxt;

  // Node occupancy
  logic [CNT_W-1:0] keys_r, keys_nxt;
  logic [CNT_W-1:0] kids_r, kids_nxt;

  // Sequencer working registers
  logic [CNT_W-1:0] idx_r,  idx_nxt;   // scan / shift read pointer
  logic [CNT_W-1:0] lim_r,  lim_nxt;   // scan limit
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;   // scan tally or moves left
  logic [CNT_W-1:0] wdst_r, wdst_nxt;  // shift write target
  logic [CNT_W-1:0] put_r,  put_nxt;   // insert slot
  logic [CNT_W-1:0] lo_r,   lo_nxt;    // binary search window [lo, hx)
  logic [CNT_W-1:0] hx_r,   hx_nxt;
  logic [CNT_W-1:0] mid_r,  mid_nxt;
  logic             pv_r,   pv_nxt;    // read in flight
  logic             sel_child_r, sel_child_nxt;
  logic             desc_r, desc_nxt;  // shift toward higher slots

  // Result being built
  status_t               res_status_r, res_status_nxt;
  logic [PW-1:0]         res_idx_r,    res_idx_nxt;
  logic [KEY_BITS-1:0]   res_key_r,    res_key_nxt;
  logic [CHILD_BITS-1:0] res_child_r,  res_child_nxt;

  // Output register
  logic                     out_valid_r,  out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [IDX_FIELD_W-1:0]   out_idx_r,    out_idx_nxt;
  logic [KEY_FIELD_W-1:0]   out_key_r,    out_key_nxt;
  logic [CHILD_FIELD_W-1:0] out_child_r,  out_child_nxt;
  logic [CNT_FIELD_W-1:0]   out_kcnt_r,   out_kcnt_nxt;
  logic [CNT_FIELD_W-1:0]   out_ccnt_r,   out_ccnt_nxt;

  // RAM ports
  logic                  k_we, c_we;
  logic [KAW-1:0]        k_wa;
  logic [CAW-1:0]        c_wa;
  logic [KEY_BITS-1:0]   k_wd, k_rdata;
  logic [CHILD_BITS-1:0] c_wd, c_rdata;
  logic [CNT_W-1:0]      ra;

  cmp_res_t cmp;

  logic [CNT_W-1:0] pos_cnt;
  logic             pos_in_keys, pos_in_kids;
  logic [CNT_W-1:0] bs_mid;
  logic [CNT_W-1:0] put_inc, child_put;

  assign pos_cnt     = CNT_W'(pos_r);
  assign pos_in_keys = (PW'(pos_r) < PW'(keys_r));
  assign pos_in_kids = (PW'(pos_r) < PW'(kids_r));
  assign bs_mid      = lo_r + ((hx_r - lo_r - CNT_W'(1)) >> 1);
  // Child goes right of the new key, clamped to the current child count
  assign put_inc     = put_r + CNT_W'(1);
  assign child_put   = (put_inc > kids_r) ? kids_r : put_inc;

  btn_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_wa),
    .wdata (k_wd),
    .raddr (KAW'(ra)),
    .rdata (k_rdata)
  );

  btn_ram #(
    .WIDTH (CHILD_BITS),
    .DEPTH (MAX_KEYS + 1)
  ) u_child_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_wa),
    .wdata (c_wd),
    .raddr (CAW'(ra)),
    .rdata (c_rdata)
  );

  // One comparator serves the key scan, the binary search and the child scan
  btn_cmp #(
    .KEY_W   (KEY_BITS),
    .CHILD_W (CHILD_BITS)
  ) u_cmp (
    .key_a   (key_r),
    .key_b   (k_rdata),
    .child_a (child_r),
    .child_b (c_rdata),
    .res     (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    child_nxt      = child_r;
    left_nxt       = left_r;
    pos_nxt        = pos_r;
    keys_nxt       = keys_r;
    kids_nxt       = kids_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    wdst_nxt       = wdst_r;
    put_nxt        = put_r;
    lo_nxt         = lo_r;
    hx_nxt         = hx_r;
    mid_nxt        = mid_r;
    pv_nxt         = pv_r;
    sel_child_nxt  = sel_child_r;
    desc_nxt       = desc_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_key_nxt    = res_key_r;
    res_child_nxt  = res_child_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_key_nxt    = out_key_r;
    out_child_nxt  = out_child_r;
    out_kcnt_nxt   = out_kcnt_r;
    out_ccnt_nxt   = out_ccnt_r;
    k_we           = 1'b0;
    k_wa           = '0;
    k_wd           = key_r;
    c_we           = 1'b0;
    c_wa           = '0;
    c_wd           = child_r;
    ra             = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = act_t'(in_action);
          key_nxt   = KEY_BITS'(in_search_key);
          child_nxt = CHILD_BITS'(in_child_id);
          left_nxt  = CHILD_BITS'(in_left_child_id);
          pos_nxt   = in_position;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_status_nxt = STS_OK;
        res_idx_nxt    = '0;
        res_key_nxt    = '0;
        res_child_nxt  = '0;
        idx_nxt        = '0;
        cnt_nxt        = '0;
        pv_nxt         = 1'b0;
        state_nxt      = S_FIN;
        case (act_r)
          ACT_INSERT: begin
            if (keys_r >= KEY_CAP || kids_r >= CHILD_CAP) begin
              res_status_nxt = STS_FULL;
            end else begin
              lim_nxt   = keys_r;
              state_nxt = S_SCAN;
            end
          end
          ACT_ROUTE: begin
            lim_nxt   = keys_r;
            state_nxt = S_SCAN;
          end
          ACT_FIND_KEY: begin
            lo_nxt    = '0;
            hx_nxt    = keys_r;
            state_nxt = S_BS_RD;
          end
          ACT_FIND_CHILD: begin
            lim_nxt   = kids_r;
            state_nxt = S_SCAN;
          end
          ACT_READ: begin
            res_idx_nxt = PW'(pos_r);
            if (!pos_in_keys && !pos_in_kids) begin
              res_status_nxt = STS_RANGE;
            end else begin
              state_nxt = S_PREAD;
            end
          end
          ACT_UPDATE: begin
            res_idx_nxt = PW'(pos_r);
            if (!pos_in_keys) begin
              res_status_nxt = STS_RANGE;
            end else begin
              k_we = 1'b1;
              k_wa = KAW'(pos_cnt);
            end
          end
          ACT_DEL_KEY: begin
            res_idx_nxt = PW'(pos_r);
            if (!pos_in_keys) begin
              res_status_nxt = STS_RANGE;
            end else begin
              sel_child_nxt = 1'b0;
              desc_nxt      = 1'b0;
              idx_nxt       = pos_cnt + CNT_W'(1);
              cnt_nxt       = keys_r - pos_cnt - CNT_W'(1);
              state_nxt     = S_SHIFT;
            end
          end
          ACT_DEL_CHILD: begin
            res_idx_nxt = PW'(pos_r);
            if (!pos_in_kids) begin
              res_status_nxt = STS_RANGE;
            end else begin
              sel_child_nxt = 1'b1;
              desc_nxt      = 1'b0;
              idx_nxt       = pos_cnt + CNT_W'(1);
              cnt_nxt       = kids_r - pos_cnt - CNT_W'(1);
              state_nxt     = S_SHIFT;
            end
          end
          ACT_START: begin
            k_we      = 1'b1;
            k_wa      = '0;
            c_we      = 1'b1;
            c_wa      = '0;
            c_wd      = left_r;
            state_nxt = S_START2;
          end
          default: ;  // unused codes answer ok with no change
        endcase
      end

      // Streaming scan: one read issued per cycle, each compared in the cycle after
      S_SCAN: begin
        if (idx_r < lim_r) begin
          ra      = idx_r;
          idx_nxt = idx_r + CNT_W'(1);
          pv_nxt  = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (act_r == ACT_FIND_CHILD) begin
            if (cmp.child_eq) begin
              res_idx_nxt   = PW'(idx_r - CNT_W'(1));
              res_child_nxt = c_rdata;
              pv_nxt        = 1'b0;
              state_nxt     = S_FIN;
            end
          end else if (!cmp.key_lt) begin
            cnt_nxt = cnt_r + CNT_W'(1);   // slot <= search key
          end
        end
        if (idx_r >= lim_r && !pv_r) begin
          case (act_r)
            ACT_INSERT: begin
              res_idx_nxt   = PW'(cnt_r);
              put_nxt       = cnt_r;
              sel_child_nxt = 1'b0;
              desc_nxt      = 1'b1;
              idx_nxt       = keys_r - CNT_W'(1);
              cnt_nxt       = keys_r - cnt_r;
              state_nxt     = S_SHIFT;
            end
            ACT_ROUTE: begin
              res_idx_nxt = PW'(cnt_r);
              idx_nxt     = cnt_r;
              if (cnt_r < kids_r) begin
                state_nxt = S_CREAD;
              end else begin
                res_status_nxt = STS_NOT_FOUND;
                state_nxt      = S_FIN;
              end
            end
            default: begin  // child scan ran out
              res_status_nxt = STS_NOT_FOUND;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end

      // Move one entry per cycle; read pointer runs one slot ahead of the write
      S_SHIFT: begin
        if (cnt_r != '0) begin
          ra       = idx_r;
          idx_nxt  = desc_r ? idx_r - CNT_W'(1) : idx_r + CNT_W'(1);
          wdst_nxt = desc_r ? idx_r + CNT_W'(1) : idx_r - CNT_W'(1);
          cnt_nxt  = cnt_r - CNT_W'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (sel_child_r) begin
            c_we = 1'b1;
            c_wa = CAW'(wdst_r);
            c_wd = c_rdata;
          end else begin
            k_we = 1'b1;
            k_wa = KAW'(wdst_r);
            k_wd = k_rdata;
          end
        end
        if (cnt_r == '0 && !pv_r) begin
          case (act_r)
            ACT_INSERT: state_nxt = S_PUT;
            ACT_DEL_KEY: begin
              keys_nxt  = keys_r - CNT_W'(1);
              state_nxt = S_FIN;
            end
            ACT_DEL_CHILD: begin
              kids_nxt  = kids_r - CNT_W'(1);
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_PUT: begin
        if (!sel_child_r) begin
          k_we          = 1'b1;
          k_wa          = KAW'(put_r);
          keys_nxt      = keys_r + CNT_W'(1);
          put_nxt       = child_put;
          sel_child_nxt = 1'b1;
          desc_nxt      = 1'b1;
          idx_nxt       = kids_r - CNT_W'(1);
          cnt_nxt       = kids_r - child_put;
          state_nxt     = S_SHIFT;
        end else begin
          c_we      = 1'b1;
          c_wa      = CAW'(put_r);
          kids_nxt  = kids_r + CNT_W'(1);
          state_nxt = S_FIN;
        end
      end

      S_CREAD: begin
        ra        = idx_r;
        state_nxt = S_CGET;
      end

      S_CGET: begin
        res_child_nxt = c_rdata;
        state_nxt     = S_FIN;
      end

      S_BS_RD: begin
        if (lo_r < hx_r) begin
          ra        = bs_mid;
          mid_nxt   = bs_mid;
          state_nxt = S_BS_CMP;
        end else begin
          res_status_nxt = STS_NOT_FOUND;
          state_nxt      = S_FIN;
        end
      end

      S_BS_CMP: begin
        state_nxt = S_BS_RD;
        if (cmp.key_lt) begin
          hx_nxt = mid_r;
        end else if (cmp.key_eq) begin
          res_idx_nxt = PW'(mid_r);
          res_key_nxt = k_rdata;
          state_nxt   = S_FIN;
        end else begin
          lo_nxt = mid_r + CNT_W'(1);
        end
      end

      S_PREAD: begin
        ra        = pos_cnt;
        state_nxt = S_PGET;
      end

      S_PGET: begin
        res_key_nxt   = pos_in_keys ? k_rdata : '0;
        res_child_nxt = pos_in_kids ? c_rdata : '0;
        state_nxt     = S_FIN;
      end

      S_START2: begin
        c_we      = 1'b1;
        c_wa      = CAW'(1);
        keys_nxt  = CNT_W'(1);
        kids_nxt  = CNT_W'(2);
        state_nxt = S_FIN;
      end

      // Hand the result over once the output register is free or being drained
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = IDX_FIELD_W'(res_idx_r);
          out_key_nxt    = KEY_FIELD_W'(res_key_r);
          out_child_nxt  = CHILD_FIELD_W'(res_child_r);
          out_kcnt_nxt   = CNT_FIELD_W'(keys_r);
          out_ccnt_nxt   = CNT_FIELD_W'(kids_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r      <= '0;
      kids_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      keys_r      <= keys_nxt;
      kids_r      <= kids_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    child_r      <= child_nxt;
    left_r       <= left_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    lim_r        <= lim_nxt;
    cnt_r        <= cnt_nxt;
    wdst_r       <= wdst_nxt;
    put_r        <= put_nxt;
    lo_r         <= lo_nxt;
    hx_r         <= hx_nxt;
    mid_r        <= mid_nxt;
    sel_child_r  <= sel_child_nxt;
    desc_r       <= desc_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_key_r    <= res_key_nxt;
    res_child_r  <= res_child_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_key_r    <= out_key_nxt;
    out_child_r  <= out_child_nxt;
    out_kcnt_r   <= out_kcnt_nxt;
    out_ccnt_r   <= out_ccnt_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_key_out     = out_key_r;
  assign out_child_out   = out_child_r;
  assign out_key_count   = out_kcnt_r;
  assign out_child_count = out_ccnt_r;

  a_key_cap: assert property (@(posedge clk) disable iff (!rst_n)
    keys_r <= KEY_CAP)
    else $error("key count above capacity");

  a_kid_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kids_r <= CHILD_CAP)
    else $error("child count above capacity");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISP))
    else $error("accepted transaction not dispatched");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result presented outside finish state");

  a_shift_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && cnt_r == '0 && !pv_r) |=> (state_r != S_SHIFT))
    else $error("shift engine did not terminate");

endmodule
